FILE: sv/mts_pkg.sv
// Shared types for the least-time search block.
`default_nettype none
package mts_pkg;
    typedef struct packed {
        logic [31:0] machine_time;
        logic        last_machine;
    } t_in;

    typedef struct packed {
        logic [63:0] min_time;
        logic        overflowed;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic load;         // store one machine time
        logic set_bounds;   // low = 1, high = target * largest
        logic probe_mid;    // start probe at midpoint
        logic probe_low;    // start final probe at low
        logic rd;           // read store at walk index
        logic div_start;    // divide probe time by read machine time
        logic accum;        // fold quotient into running sum
        logic update;       // move a search bound
        logic emit;         // load result, clear the set
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic low_lt_high;
        logic walk_end;
        logic mem_zero;
        logic div_done;
        logic out_free;
    } t_stat;
endpackage
`default_nettype wire

FILE: sv/mts_div.sv
// Iterative 64 by 32 bit unsigned divider, one quotient bit per cycle.
`default_nettype none
module mts_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic      [63:0] o_quot,
    output logic             o_done
);
    logic [63:0] r_q;
    logic [31:0] r_rem, r_d;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] rem_sh;
    logic        ge;

    assign rem_sh = {r_rem, r_q[63]};
    assign ge     = rem_sh >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? 32'(rem_sh - {1'b0, r_d}) : rem_sh[31:0];
            r_q   <= {r_q[62:0], ge};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

    a_busy_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_cnt == 6'd63 |=> r_done && !r_busy)
        else $error("divider left busy without done");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while busy");
endmodule
`default_nettype wire

FILE: sv/mts_dp.sv
// Datapath: machine store, search bounds, probe sum and result register.
`default_nettype none
module mts_dp import mts_pkg::*; #(
    parameter int MAX_MACHINES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire t_in         i_in_data,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data
);
    localparam int AW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int CW = $clog2(MAX_MACHINES + 1);
    localparam logic [CW-1:0] CapCount = CW'(MAX_MACHINES);

    logic [31:0]   mem [MAX_MACHINES];
    logic [31:0]   r_mem_q;
    logic [31:0]   r_target, r_largest;
    logic [CW-1:0] r_count, r_k;
    logic          r_dropped, r_hit;
    logic [63:0]   r_low, r_high, r_t;
    logic [32:0]   r_sum;
    logic [63:0]   quot;
    logic          div_done;
    logic [64:0]   mid_sum;
    logic [31:0]   need;

    mts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_t),
        .i_divisor  (r_mem_q),
        .o_quot     (quot),
        .o_done     (div_done)
    );

    assign mid_sum = {1'b0, r_low} + {1'b0, r_high};
    assign need    = 32'(({1'b0, r_target}) - r_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < CapCount) mem[r_count[AW-1:0]] <= i_in_data.machine_time;
        if (i_cmd.rd) r_mem_q <= mem[r_k[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 32'd1;
            r_count     <= '0;
            r_largest   <= '0;
            r_dropped   <= 1'b0;
            r_low       <= 64'd1;
            r_high      <= '0;
            r_sum       <= '0;
            r_hit       <= 1'b0;
            r_k         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_target <= i_cfg_wdata;
            // a new result may replace one leaving in the same cycle
            if (i_cmd.emit) o_out_valid <= 1'b1;
            else if (!i_out_stall) o_out_valid <= 1'b0;
            if (i_cmd.load) begin
                if (r_count < CapCount) begin
                    r_count <= r_count + CW'(1);
                    if (i_in_data.machine_time > r_largest)
                        r_largest <= i_in_data.machine_time;
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (i_cmd.set_bounds) begin
                r_low  <= 64'd1;
                r_high <= r_target * r_largest;
            end
            if (i_cmd.probe_mid || i_cmd.probe_low) begin
                r_t   <= i_cmd.probe_mid ? mid_sum[64:1] : r_low;
                r_sum <= '0;
                r_k   <= '0;
                r_hit <= (r_target == 32'd0);
            end
            if (i_cmd.rd) r_k <= r_k + CW'(1);
            if (i_cmd.accum) begin
                if (quot >= {32'd0, need}) r_hit <= 1'b1;
                else r_sum <= r_sum + quot[32:0];
            end
            if (i_cmd.update) begin
                if (r_hit) r_high <= r_t;
                else r_low <= r_t + 64'd1;
            end
            if (i_cmd.emit) begin
                o_out_data.min_time   <= r_hit ? r_low : '1;
                o_out_data.overflowed <= r_dropped;
                r_count   <= '0;
                r_largest <= '0;
                r_dropped <= 1'b0;
                r_low     <= 64'd1;
                r_high    <= '0;
                r_sum     <= '0;
            end
        end
    end

    always_comb begin
        o_stat.low_lt_high = r_low < r_high;
        o_stat.walk_end    = r_hit || (r_k == r_count);
        o_stat.mem_zero    = (r_mem_q == 32'd0);
        o_stat.div_done    = div_done;
        o_stat.out_free    = !o_out_valid || !i_out_stall;
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CapCount)
        else $error("machine count beyond capacity");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> r_mem_q != 32'd0)
        else $error("division by zero machine time");
endmodule
`default_nettype wire

FILE: sv/mts_ctrl.sv
// Controller: load phase, binary search and per-probe machine walk.
`default_nettype none
module mts_ctrl import mts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_last,
    output logic      o_in_stall,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_BOUNDS, S_CHECK, S_WALK, S_RD, S_DIV, S_DECIDE, S_OUT
    } t_state;

    t_state r_state;
    logic   r_final;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:   o_cmd.load       = i_in_valid;
            S_BOUNDS: o_cmd.set_bounds = 1'b1;
            S_CHECK: begin
                o_cmd.probe_mid = i_stat.low_lt_high;
                o_cmd.probe_low = !i_stat.low_lt_high;
            end
            S_WALK:   o_cmd.rd        = !i_stat.walk_end;
            S_RD:     o_cmd.div_start = !i_stat.mem_zero;
            S_DIV:    o_cmd.accum     = i_stat.div_done;
            S_DECIDE: o_cmd.update    = !r_final;
            S_OUT:    o_cmd.emit      = i_stat.out_free;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE:   if (i_in_valid && i_last) r_state <= S_BOUNDS;
                S_BOUNDS: r_state <= S_CHECK;
                S_CHECK: begin
                    r_final <= !i_stat.low_lt_high;
                    r_state <= S_WALK;
                end
                S_WALK:   r_state <= i_stat.walk_end ? S_DECIDE : S_RD;
                S_RD:     r_state <= i_stat.mem_zero ? S_WALK : S_DIV;
                S_DIV:    if (i_stat.div_done) r_state <= S_WALK;
                S_DECIDE: r_state <= r_final ? S_OUT : S_CHECK;
                S_OUT:    if (i_stat.out_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    a_emit_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> r_final)
        else $error("result emitted before final probe");
    a_div_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> $past(o_cmd.rd))
        else $error("divide started without a store read");
endmodule
`default_nettype wire

FILE: sv/min_time_binary_search.sv
// Top level of the least-time search block over a set of machines.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------
//  input     | in        | i_in_valid / o_in_stall    | i_in_data
//  output    | out       | o_out_valid / i_out_stall  | o_out_data
//  config    | in        | i_cfg_we                   | i_cfg_wdata
//
// Machine times load one transfer per cycle into the store while the controller is idle.
// After the last-marked transfer the search runs: up to 65 probes, each
// walking the stored machines and dividing the probe time by each nonzero
// machine time in the bit-serial 64/32 divider; a probe ends early on reaching target.
// Reset is synchronous, active low; the store holds no reset value.
// Input transfers are taken while a result waits on a stalled output.
`default_nettype none
module min_time_binary_search import mts_pkg::*; #(
    parameter int MAX_MACHINES = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);
    t_cmd  cmd;
    t_stat stat;

    mts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in_data.last_machine),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mts_dp #(.MAX_MACHINES(MAX_MACHINES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire
